[rtl/ledser_pkg.sv]
// ============================================================================
// ledser_pkg: shared definitions for the LED strip color serializer
// Strip size, input mode codes, register indexes and the control and status
// structs between the controller and the datapath.
// ============================================================================
package ledser_pkg;

  // Strip geometry.
  localparam int LED_COUNT    = 16;
  localparam int BITS_PER_LED = 24;
  localparam int LED_IDX_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int BIT_IDX_W    = $clog2(BITS_PER_LED);

  // Field widths.
  localparam int MODE_W  = 2;
  localparam int INDEX_W = 8;
  localparam int COLOR_W = 24;
  localparam int CODE_W  = 8;
  localparam int CFG_IDX_W = 8;

  // Index that addresses every LED at once.
  localparam logic [INDEX_W-1:0] ALL_INDEX = 8'hFF;

  // Register reset values.
  localparam logic [CODE_W-1:0] ONE_CODE_RESET  = 8'hF8;
  localparam logic [CODE_W-1:0] ZERO_CODE_RESET = 8'h80;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ONE_CODE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_CODE = 8'd1;

  // Input item kinds.
  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_START = 2'd2,
    MODE_TICK  = 2'd3
  } mode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write_color;  // store the color at the item's index
    logic clear_all;    // zero every LED
    logic ptr_reset;    // point at the first bit of the first LED
    logic ptr_advance;  // step to the next color bit
    logic emit;         // push one symbol to the output stage
    logic emit_data;    // symbol is the coded color bit, else zero
    logic emit_last;    // symbol closes the frame
  } ledser_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ptr_at_end;   // pointer is on the final bit of the final LED
  } ledser_status_t;

endpackage

[rtl/ledser_ctrl.sv]
// ============================================================================
// ledser_ctrl: frame sequencer
// Decodes each accepted item against the frame state and issues datapath
// commands: color writes and clears while idle, symbol emission on ticks.
// ============================================================================
module ledser_ctrl import ledser_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  mode_t          mode,
  input  ledser_status_t status,
  output ledser_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEAD,
    S_DATA,
    S_TRAIL
  } state_t;

  state_t state;
  state_t state_next;

  logic tick;
  assign tick = accept && (mode == MODE_TICK);

  // Command decode and next state.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_WRITE: cmd.write_color = 1'b1;
            MODE_CLEAR: cmd.clear_all   = 1'b1;
            MODE_START: state_next      = S_LEAD;
            default:    ;
          endcase
        end
      end
      S_LEAD: begin
        if (tick) begin
          cmd.emit      = 1'b1;
          cmd.ptr_reset = 1'b1;
          state_next    = S_DATA;
        end
      end
      S_DATA: begin
        if (tick) begin
          cmd.emit        = 1'b1;
          cmd.emit_data   = 1'b1;
          cmd.ptr_advance = 1'b1;
          if (status.ptr_at_end) begin
            state_next = S_TRAIL;
          end
        end
      end
      S_TRAIL: begin
        if (tick) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  a_no_store_in_frame: assert property (@(posedge clk) disable iff (rst)
    (cmd.write_color || cmd.clear_all) |-> (state == S_IDLE && !cmd.emit))
    else $error("store changed while a frame is running");

  a_trail_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (state == S_TRAIL && tick) |=> (state == S_IDLE))
    else $error("trailing slot did not end the frame");

  a_last_from_trail: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_last |-> (state == S_TRAIL && cmd.emit && !cmd.emit_data))
    else $error("frame end marked outside the trailing slot");
`endif

endmodule

[rtl/ledser_datapath.sv]
// ============================================================================
// ledser_datapath: color store, bit pointer and symbol coder
// Holds one color per LED and the two timing codes, walks the store bit by
// bit on command and forms each symbol for the output stage.
// ============================================================================
module ledser_datapath import ledser_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  ledser_cmd_t          cmd,
  input  logic [INDEX_W-1:0]   led_index,
  input  logic [COLOR_W-1:0]   color,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CODE_W-1:0]    cfg_data,
  output ledser_status_t       status,
  output logic                 push,
  output logic [CODE_W-1:0]    push_symbol,
  output logic                 push_last
);

  localparam logic [LED_IDX_W-1:0] LED_LAST = LED_IDX_W'(LED_COUNT - 1);
  localparam logic [BIT_IDX_W-1:0] BIT_TOP  = BIT_IDX_W'(BITS_PER_LED - 1);

  logic [COLOR_W-1:0]   led_colors [LED_COUNT];
  logic [CODE_W-1:0]    one_code;
  logic [CODE_W-1:0]    zero_code;
  logic [LED_IDX_W-1:0] led_ptr;
  logic [BIT_IDX_W-1:0] bit_ptr;

  logic               in_range;
  logic [COLOR_W-1:0] cur_word;
  logic               cur_bit;

  assign in_range = ({1'b0, led_index} < (INDEX_W + 1)'(LED_COUNT));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      one_code  <= ONE_CODE_RESET;
      zero_code <= ZERO_CODE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_ONE_CODE) begin
        one_code <= cfg_data;
      end else if (cfg_index == REG_ZERO_CODE) begin
        zero_code <= cfg_data;
      end
    end
  end

  // Color store: single writes, broadcast writes and clears.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        led_colors[i] <= '0;
      end
    end else if (cmd.clear_all) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        led_colors[i] <= '0;
      end
    end else if (cmd.write_color) begin
      if (in_range) begin
        led_colors[led_index[LED_IDX_W-1:0]] <= color;
      end else if (led_index == ALL_INDEX) begin
        for (int i = 0; i < LED_COUNT; i++) begin
          led_colors[i] <= color;
        end
      end
    end
  end

  // Bit pointer: LED in index order, color bits from the top down.
  always_ff @(posedge clk) begin
    if (rst) begin
      led_ptr <= '0;
      bit_ptr <= BIT_TOP;
    end else if (cmd.ptr_reset) begin
      led_ptr <= '0;
      bit_ptr <= BIT_TOP;
    end else if (cmd.ptr_advance) begin
      if (bit_ptr == '0) begin
        bit_ptr <= BIT_TOP;
        led_ptr <= (led_ptr == LED_LAST) ? '0 : led_ptr + 1'b1;
      end else begin
        bit_ptr <= bit_ptr - 1'b1;
      end
    end
  end

  assign status.ptr_at_end = (led_ptr == LED_LAST) && (bit_ptr == '0);

  // Symbol coding from the current color bit.
  assign cur_word    = led_colors[led_ptr];
  assign cur_bit     = cur_word[bit_ptr];
  assign push        = cmd.emit;
  assign push_last   = cmd.emit_last;
  assign push_symbol = !cmd.emit_data ? '0 : (cur_bit ? one_code : zero_code);

endmodule

[rtl/ledser_out_buf.sv]
// ============================================================================
// ledser_out_buf: two-entry output stage
// An output register with a skid entry behind it, so the input side keeps
// moving while a symbol waits on the output side.
// ============================================================================
module ledser_out_buf import ledser_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [CODE_W-1:0] push_symbol,
  input  logic              push_last,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CODE_W-1:0] out_symbol,
  output logic              out_last
);

  logic              main_valid;
  logic [CODE_W-1:0] main_symbol;
  logic              main_last;
  logic              skid_valid;
  logic [CODE_W-1:0] skid_symbol;
  logic              skid_last;
  logic              pop;

  assign pop        = main_valid && out_ready;
  assign full       = skid_valid;
  assign out_valid  = main_valid;
  assign out_symbol = main_symbol;
  assign out_last   = main_last;

  // Valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        main_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_symbol <= skid_symbol;
        main_last   <= skid_last;
      end else if (push) begin
        main_symbol <= push_symbol;
        main_last   <= push_last;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_symbol <= push_symbol;
        skid_last   <= push_last;
      end else begin
        main_symbol <= push_symbol;
        main_last   <= push_last;
      end
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry held without an output entry");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("symbol pushed into a full output stage");
`endif

endmodule

[rtl/led_strip_color_serializer.sv]
// ============================================================================
// led_strip_color_serializer: LED strip color store and symbol serializer
// Stores one 24-bit color per LED and sends the strip as timing symbols.
// ============================================================================
// An item can be accepted in every cycle in which s_tready is high. Write,
// clear and start items change state only; a tick item during a frame yields
// one symbol. A frame is LED_COUNT*24+2 ticks: a zero lead slot, every color
// bit MSB first as one_code or zero_code, and a zero trail slot flagged by
// m_tlast. Writes, clears and starts during a frame are dropped, as are ticks
// outside one. The output side holds up to two symbols; s_tready falls only
// when both entries are waiting on m_tready.
module led_strip_color_serializer import ledser_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // Input items.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // led_index[7:0], color[31:8]
  input  logic [MODE_W-1:0]    s_tuser,   // mode[1:0]
  // Result items.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [CODE_W-1:0]    m_tdata,   // symbol[7:0]
  output logic                 m_tlast,
  // Configuration writes.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CODE_W-1:0]    cfg_data
);

  ledser_cmd_t       cmd;
  ledser_status_t    status;
  logic              accept;
  logic              buf_full;
  logic              push;
  logic [CODE_W-1:0] push_symbol;
  logic              push_last;
  mode_t             mode;

  // Input handshake.
  assign s_tready  = !buf_full;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign mode      = mode_t'(s_tuser);

  ledser_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .mode   (mode),
    .status (status),
    .cmd    (cmd)
  );

  ledser_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .led_index   (s_tdata[INDEX_W-1:0]),
    .color       (s_tdata[INDEX_W+COLOR_W-1:INDEX_W]),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .status      (status),
    .push        (push),
    .push_symbol (push_symbol),
    .push_last   (push_last)
  );

  ledser_out_buf u_out_buf (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_symbol (push_symbol),
    .push_last   (push_last),
    .full        (buf_full),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_symbol  (m_tdata),
    .out_last    (m_tlast)
  );

endmodule
